// ===== rtl/core/collision_velocity_response_unit_assert.svh =====
// assertion macros for the collision velocity response unit
`ifndef COLLISION_VELOCITY_RESPONSE_UNIT_ASSERT_SVH
`define COLLISION_VELOCITY_RESPONSE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CVR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CVR_ASSERT(lbl, clk, rstn, prop, msg)
`define CVR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/cvr_pkg.sv =====
// shared constants, types and helpers of the collision velocity response unit
`default_nettype none
package cvr_pkg;

  localparam int FracBits   = 16;
  localparam int SpeedW     = 32;
  localparam int MassW      = 32;
  localparam int RestW      = FracBits + 1;
  localparam int WeightBits = 30;
  localparam int FactorBits = 28;
  localparam int QuotW      = WeightBits + 1;
  localparam int DenW       = MassW + 1;
  localparam int NumW       = MassW + WeightBits + 1;
  localparam int DiffW      = SpeedW + 1;
  localparam int EsumW      = RestW + 1;
  localparam int FactW      = FracBits + 3;
  localparam int GW         = QuotW + FactW;
  localparam int WideW      = SpeedW + 8;

  typedef enum logic [1:0] {
    CaseNone     = 2'd0,
    CaseCentral  = 2'd1,
    CasePlatform = 2'd2,
    CaseResting  = 2'd3
  } cvr_case_e;

  // per-item data that travels next to the divider
  typedef struct packed {
    logic signed [SpeedW-1:0] v1;
    logic signed [SpeedW-1:0] v2;
    logic signed [DiffW-1:0]  d;
    logic [EsumW-1:0]         esum;
    cvr_case_e                kind;
    logic                     first_moves;
    logic                     mass_zero;
  } cvr_side_t;

  // saturate a wide signed value to the speed range
  function automatic logic signed [SpeedW-1:0] sat_speed(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(signed'({1'b0, {(SpeedW-1){1'b1}}}));
    lo = -hi - WideW'(1);
    if (v > hi) begin
      sat_speed = hi[SpeedW-1:0];
    end else if (v < lo) begin
      sat_speed = lo[SpeedW-1:0];
    end else begin
      sat_speed = v[SpeedW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cvr_if.sv =====
// valid/ready channels for collision words and response words
`default_nettype none
interface cvr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cvr_pkg::SpeedW-1:0]       first_speed;
  logic [cvr_pkg::MassW-1:0]               first_mass;
  logic [cvr_pkg::RestW-1:0]               first_restitution;
  logic                                    first_movable;
  logic signed [cvr_pkg::SpeedW-1:0]       second_speed;
  logic [cvr_pkg::MassW-1:0]               second_mass;
  logic [cvr_pkg::RestW-1:0]               second_restitution;
  logic                                    second_movable;
  logic                                    resting_contact;

  modport source (output valid, first_speed, first_mass, first_restitution, first_movable,
                  second_speed, second_mass, second_restitution, second_movable,
                  resting_contact, input ready);
  modport sink (input valid, first_speed, first_mass, first_restitution, first_movable,
                second_speed, second_mass, second_restitution, second_movable,
                resting_contact, output ready);
endinterface

interface cvr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cvr_pkg::SpeedW-1:0] new_first_speed;
  logic signed [cvr_pkg::SpeedW-1:0] new_second_speed;
  logic [1:0]                        case_taken;

  modport source (output valid, new_first_speed, new_second_speed, case_taken, input ready);
  modport sink (input valid, new_first_speed, new_second_speed, case_taken, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cvr_front.sv =====
// input stage: restitution clamp, case decode, divider operands
`default_nettype none
module cvr_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              vld_i,
  input  wire logic signed [cvr_pkg::SpeedW-1:0] v1_i,
  input  wire logic [cvr_pkg::MassW-1:0]         m1_i,
  input  wire logic [cvr_pkg::RestW-1:0]         r1_i,
  input  wire logic                              mv1_i,
  input  wire logic signed [cvr_pkg::SpeedW-1:0] v2_i,
  input  wire logic [cvr_pkg::MassW-1:0]         m2_i,
  input  wire logic [cvr_pkg::RestW-1:0]         r2_i,
  input  wire logic                              mv2_i,
  input  wire logic                              rest_i,
  output logic                                   vld_o,
  output logic [cvr_pkg::NumW-1:0]               num_o,
  output logic [cvr_pkg::DenW-1:0]               den_o,
  output cvr_pkg::cvr_side_t                     side_o
);

  localparam logic [cvr_pkg::RestW-1:0] One = cvr_pkg::RestW'(1) << cvr_pkg::FracBits;

  logic [cvr_pkg::RestW-1:0]  r1c, r2c;
  logic [cvr_pkg::DenW-1:0]   sum;
  cvr_pkg::cvr_side_t         side_d, side_q;
  logic [cvr_pkg::NumW-1:0]   num_d, num_q;
  logic [cvr_pkg::DenW-1:0]   den_q;
  logic                       vld_q;
  logic signed [cvr_pkg::DiffW-1:0] d12;

  // clamp factors, mass sum and numerator of the weight
  always_comb begin
    r1c   = (r1_i > One) ? One : r1_i;
    r2c   = (r2_i > One) ? One : r2_i;
    sum   = {1'b0, m1_i} + {1'b0, m2_i};
    num_d = {1'b0, m2_i, {cvr_pkg::WeightBits{1'b0}}}
          + cvr_pkg::NumW'(sum >> 1);
    d12   = cvr_pkg::DiffW'(v1_i) - cvr_pkg::DiffW'(v2_i);
  end

  // case decode
  always_comb begin
    side_d.v1          = v1_i;
    side_d.v2          = v2_i;
    side_d.d           = d12;
    side_d.esum        = {1'b0, r1c} + {1'b0, r2c};
    side_d.first_moves = mv1_i;
    side_d.mass_zero   = (sum == '0);
    side_d.kind        = cvr_pkg::CaseNone;
    if (rest_i) begin
      side_d.kind = cvr_pkg::CaseResting;
      if (!mv1_i) begin
        side_d.v2 = v1_i;
      end else if (!mv2_i) begin
        side_d.v1 = v2_i;
      end else begin
        side_d.v1 = '0;
        side_d.v2 = '0;
      end
    end else if (mv1_i && mv2_i) begin
      side_d.kind = cvr_pkg::CaseCentral;
    end else if (mv1_i || mv2_i) begin
      side_d.kind = cvr_pkg::CasePlatform;
      if (!mv1_i) begin
        side_d.d = -d12;
      end
    end
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      num_q  <= num_d;
      den_q  <= sum;
    end
  end

  assign vld_o  = vld_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

// ===== rtl/core/cvr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
`include "collision_velocity_response_unit_assert.svh"
module cvr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire logic [cvr_pkg::NumW-1:0]    num_i,
  input  wire logic [cvr_pkg::DenW-1:0]    den_i,
  input  wire cvr_pkg::cvr_side_t          side_i,
  output logic                             vld_o,
  output logic [cvr_pkg::QuotW-1:0]        quot_o,
  output cvr_pkg::cvr_side_t               side_o
);

  localparam int Stages = cvr_pkg::QuotW;
  localparam int CmpW   = cvr_pkg::NumW + 1;

  logic                         vld_q  [Stages];
  logic [cvr_pkg::NumW-1:0]     rem_q  [Stages];
  logic [cvr_pkg::DenW-1:0]     den_q  [Stages];
  logic [cvr_pkg::QuotW-1:0]    quot_q [Stages];
  cvr_pkg::cvr_side_t           side_q [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic                      vin;
    logic [cvr_pkg::NumW-1:0]  rin;
    logic [cvr_pkg::DenW-1:0]  din;
    logic [cvr_pkg::QuotW-1:0] qin;
    cvr_pkg::cvr_side_t        sin;
    logic [CmpW-1:0]           shifted;
    logic                      take;

    if (k == 0) begin : g_first
      assign vin = vld_i;
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quot_q[k-1];
      assign sin = side_q[k-1];
    end

    // trial subtract of the divisor aligned to this bit
    assign shifted = CmpW'(din) << (Stages - 1 - k);
    assign take    = ({1'b0, rin} >= shifted);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? cvr_pkg::NumW'({1'b0, rin} - shifted) : rin;
        den_q[k]  <= din;
        quot_q[k] <= {qin[cvr_pkg::QuotW-2:0], take};
        side_q[k] <= sin;
      end
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign quot_o = quot_q[Stages-1];
  assign side_o = side_q[Stages-1];

  // checks on the finished quotient
  `CVR_ASSERT(a_rem_below_den, clk_i, rst_ni, vld_q[Stages-1] && (den_q[Stages-1] != '0) |-> CmpW'(rem_q[Stages-1]) < CmpW'(den_q[Stages-1]), "divider remainder not below divisor")
  `CVR_ASSERT(a_weight_range, clk_i, rst_ni, vld_q[Stages-1] && (den_q[Stages-1] != '0) |-> quot_q[Stages-1] <= (cvr_pkg::QuotW'(1) << cvr_pkg::WeightBits), "mass weight above one")
  `CVR_ASSERT(a_stall_holds, clk_i, rst_ni, !en_i |=> $stable(vld_q[Stages-1]) && $stable(quot_q[Stages-1]), "divider moved during stall")

endmodule
`default_nettype wire

// ===== rtl/core/cvr_back.sv =====
// response stages: factor, products, rounding, saturation
`default_nettype none
module cvr_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              vld_i,
  input  wire logic [cvr_pkg::QuotW-1:0]         quot_i,
  input  wire cvr_pkg::cvr_side_t                side_i,
  output logic                                   vld_o,
  output logic signed [cvr_pkg::SpeedW-1:0]      n1_o,
  output logic signed [cvr_pkg::SpeedW-1:0]      n2_o,
  output cvr_pkg::cvr_case_e                     kind_o
);

  localparam int F   = cvr_pkg::FracBits;
  localparam int P1W = cvr_pkg::QuotW + 1 + cvr_pkg::DiffW;
  localparam int P2W = cvr_pkg::EsumW + 1 + cvr_pkg::DiffW;
  localparam int R1W = P1W - cvr_pkg::FactorBits;
  localparam int R2W = P2W - (F + 1);
  localparam int WW  = cvr_pkg::WideW;

  logic                        vld1_q, vld2_q, vld3_q, vld4_q;
  cvr_pkg::cvr_side_t          s1_q, s2_q, s3_q;
  logic [cvr_pkg::GW-1:0]      g_q;
  logic [cvr_pkg::QuotW-1:0]   w;
  logic [cvr_pkg::FactW-1:0]   fac;
  logic [cvr_pkg::GW-1:0]      gr;
  logic [cvr_pkg::QuotW-1:0]   q;
  logic signed [P1W-1:0]       p1_q;
  logic signed [P2W-1:0]       p2_q;
  logic signed [R1W-1:0]       r1;
  logic signed [R2W-1:0]       r2;
  logic signed [WW-1:0]        n1c, n2c, nplat, pv;
  logic signed [WW-1:0]        n1_q, n2_q, np_q;
  logic signed [cvr_pkg::SpeedW-1:0] o1_q, o2_q;
  cvr_pkg::cvr_case_e          k_q;

  function automatic logic [cvr_pkg::QuotW-1:0] s1_mass_zero_sel(
      input logic zero, input logic [cvr_pkg::QuotW-1:0] qv);
    s1_mass_zero_sel = zero ? (cvr_pkg::QuotW'(1) << (cvr_pkg::WeightBits - 1)) : qv;
  endfunction

  // stage 1: weight times (1 + e)
  always_comb begin
    w   = s1_mass_zero_sel(side_i.mass_zero, quot_i);
    fac = (cvr_pkg::FactW'(1) << (F + 1)) + cvr_pkg::FactW'(side_i.esum);
  end

  // stage 2: round factor, form both products
  always_comb begin
    gr = g_q + (cvr_pkg::GW'(1) << (F + 2));
    q  = cvr_pkg::QuotW'(gr >> (F + 3));
  end

  // stage 3: round products, build speeds
  always_comb begin
    r1    = R1W'((p1_q + (P1W'(1) << (cvr_pkg::FactorBits - 1))) >>> cvr_pkg::FactorBits);
    r2    = R2W'((p2_q + (P2W'(1) << F)) >>> (F + 1));
    n1c   = WW'(s2_q.v1) - WW'(r1);
    n2c   = n1c + WW'(r2);
    pv    = s2_q.first_moves ? WW'(s2_q.v2) : WW'(s2_q.v1);
    nplat = pv - WW'(r2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      g_q  <= cvr_pkg::GW'(w) * cvr_pkg::GW'(fac);
      s1_q <= side_i;
      // stage 2
      p1_q <= P1W'($signed({1'b0, q})) * P1W'(s1_q.d);
      p2_q <= P2W'($signed({1'b0, s1_q.esum})) * P2W'(s1_q.d);
      s2_q <= s1_q;
      // stage 3 registers the speeds built from the s2 products
      s3_q <= s2_q;
      // stage 4: select and saturate
      k_q  <= s3_q.kind;
      case (s3_q.kind)
        cvr_pkg::CaseCentral: begin
          o1_q <= cvr_pkg::sat_speed(n1_q);
          o2_q <= cvr_pkg::sat_speed(n2_q);
        end
        cvr_pkg::CasePlatform: begin
          o1_q <= s3_q.first_moves ? cvr_pkg::sat_speed(np_q) : s3_q.v1;
          o2_q <= s3_q.first_moves ? s3_q.v2 : cvr_pkg::sat_speed(np_q);
        end
        default: begin
          o1_q <= s3_q.v1;
          o2_q <= s3_q.v2;
        end
      endcase
    end
  end

  // products must line up with the side data of the same word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q <= n1c;
      n2_q <= n2c;
      np_q <= nplat;
    end
  end

  assign vld_o  = vld4_q;
  assign n1_o   = o1_q;
  assign n2_o   = o2_q;
  assign kind_o = k_q;

endmodule
`default_nettype wire

// ===== rtl/core/collision_velocity_response_unit.sv =====
// top level of the collision velocity response unit
// One collision word is taken per cycle unless the response channel stalls, and each word
// passes through one operand stage, 31 divider stages, one multiply stage, one product
// stage, one rounding stage and one output register. Most of the depth is set by the
// radix-2 divider that forms the mass weight m2/(m1+m2) one quotient bit per stage.
// Back-pressure on the response channel freezes the whole pipeline; no word is lost or repeated.
`default_nettype none
`include "collision_velocity_response_unit_assert.svh"
module collision_velocity_response_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cvr_in_if.sink     in_i,
  cvr_out_if.source  out_o
);

  logic                              en;
  logic                              f_vld, d_vld, b_vld;
  logic [cvr_pkg::NumW-1:0]          f_num;
  logic [cvr_pkg::DenW-1:0]          f_den;
  cvr_pkg::cvr_side_t                f_side, d_side;
  logic [cvr_pkg::QuotW-1:0]         d_quot;
  logic signed [cvr_pkg::SpeedW-1:0] n1, n2;
  cvr_pkg::cvr_case_e                kind;

  // pipeline advances unless the output word is held
  assign en         = !b_vld || out_o.ready;
  assign in_i.ready = en;

  cvr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid),
    .v1_i   (in_i.first_speed),
    .m1_i   (in_i.first_mass),
    .r1_i   (in_i.first_restitution),
    .mv1_i  (in_i.first_movable),
    .v2_i   (in_i.second_speed),
    .m2_i   (in_i.second_mass),
    .r2_i   (in_i.second_restitution),
    .mv2_i  (in_i.second_movable),
    .rest_i (in_i.resting_contact),
    .vld_o  (f_vld),
    .num_o  (f_num),
    .den_o  (f_den),
    .side_o (f_side)
  );

  cvr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .num_i  (f_num),
    .den_i  (f_den),
    .side_i (f_side),
    .vld_o  (d_vld),
    .quot_o (d_quot),
    .side_o (d_side)
  );

  cvr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld),
    .quot_i (d_quot),
    .side_i (d_side),
    .vld_o  (b_vld),
    .n1_o   (n1),
    .n2_o   (n2),
    .kind_o (kind)
  );

  // response word
  assign out_o.valid            = b_vld;
  assign out_o.new_first_speed  = n1;
  assign out_o.new_second_speed = n2;
  assign out_o.case_taken       = kind;

  `CVR_ASSERT(a_rest_common, clk_i, rst_ni, b_vld && (kind == cvr_pkg::CaseResting) |-> n1 == n2, "resting contact speeds differ")

endmodule
`default_nettype wire
